>>> sv/tlpm_pkg.sv
// tlpm_pkg: shared types and constants of the thin-lens phase mask
// holds defaults, config register indexes, cordic table and pipeline control type
// no dependencies
package tlpm_pkg;

    // defaults for the top level parameters
    localparam int MAX_GRID_DEF    = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    // fixed field widths
    localparam int IDX_W     = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;
    localparam int PHASE_W   = 32;
    localparam int APER_W    = 20;
    localparam int GRID_W    = 11;
    localparam int PHASOR_W  = 16;

    // cordic datapath: 30 fraction bits plus headroom
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_W     = 33;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [PHASE_W-1:0] HALF_TURN    = 32'h8000_0000;

    // arctangent of 2^-i as a fraction of a turn times 2^32
    localparam logic [PHASE_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
    };

    // rounding offset for the Q1.15 conversion
    localparam int ROUND_HALF = 16384;
    localparam int FRAC_SHIFT = 15;

    // config register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LENS_KIND  = 2'd0,
        CFG_PHASE_STEP = 2'd1,
        CFG_APERTURE   = 2'd2,
        CFG_GRID_SIZE  = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        LENS_CONVEX  = 1'b0,
        LENS_CONCAVE = 1'b1
    } t_lens_kind;

    // reset values of the config registers
    localparam logic [APER_W-1:0] APER_RESET = 20'h80000;
    localparam logic [GRID_W-1:0] GRID_RESET = 11'd256;

    // pipeline control handed to the cordic
    typedef struct packed {
        logic en;
        logic valid;
    } t_pipe_ctl;

endpackage

>>> sv/tlpm_cordic.sv
// tlpm_cordic: pipelined rotation-mode cordic, one iteration per register stage
// produces cos and sin with 30 fraction bits, sideband travels alongside
// depends on tlpm_pkg
module tlpm_cordic #(
    parameter int SIDE_W = 1
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  tlpm_pkg::t_pipe_ctl                        i_ctl,
    input  logic signed [tlpm_pkg::CORDIC_W-1:0]       i_z,
    input  logic [SIDE_W-1:0]                          i_side,
    output logic                                       o_valid,
    output logic signed [tlpm_pkg::CORDIC_W-1:0]       o_x,
    output logic signed [tlpm_pkg::CORDIC_W-1:0]       o_y,
    output logic [SIDE_W-1:0]                          o_side
);

    localparam int N = tlpm_pkg::CORDIC_STEPS;
    localparam int W = tlpm_pkg::CORDIC_W;

    logic signed [W-1:0] w_x [N+1];
    logic signed [W-1:0] w_y [N+1];
    logic signed [W-1:0] w_z [N];
    logic [SIDE_W-1:0]   w_side [N+1];
    logic                w_valid [N+1];

    assign w_x[0]     = tlpm_pkg::CORDIC_GAIN;
    assign w_y[0]     = '0;
    assign w_z[0]     = i_z;
    assign w_side[0]  = i_side;
    assign w_valid[0] = i_ctl.valid;

    for (genvar g = 0; g < N; g++) begin : g_step
        logic signed [W-1:0] w_xs, w_ys;
        logic signed [W-1:0] n_x, n_y, n_z;
        logic signed [W-1:0] r_x, r_y;
        logic [SIDE_W-1:0]   r_side;
        logic                r_valid;

        // one micro-rotation, shifts floor toward minus infinity
        always_comb begin
            w_xs = w_x[g] >>> g;
            w_ys = w_y[g] >>> g;
            if (!w_z[g][W-1]) begin
                n_x = w_x[g] - w_ys;
                n_y = w_y[g] + w_xs;
                n_z = w_z[g] - $signed({1'b0, tlpm_pkg::ATAN_TURNS[g]});
            end else begin
                n_x = w_x[g] + w_ys;
                n_y = w_y[g] - w_xs;
                n_z = w_z[g] + $signed({1'b0, tlpm_pkg::ATAN_TURNS[g]});
            end
        end

        // stage valid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid <= 1'b0;
            end else if (i_ctl.en) begin
                r_valid <= w_valid[g];
            end
        end

        // stage payload
        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_x    <= n_x;
                r_y    <= n_y;
                r_side <= w_side[g];
            end
        end

        // residual angle is not needed after the last step
        if (g < N - 1) begin : g_z
            logic signed [W-1:0] r_z;
            always_ff @(posedge i_clk) begin
                if (i_ctl.en) begin
                    r_z <= n_z;
                end
            end
            assign w_z[g+1] = r_z;
        end

        assign w_x[g+1]     = r_x;
        assign w_y[g+1]     = r_y;
        assign w_side[g+1]  = r_side;
        assign w_valid[g+1] = r_valid;
    end

    assign o_valid = w_valid[N];
    assign o_x     = w_x[N];
    assign o_y     = w_y[N];
    assign o_side  = w_side[N];

endmodule

>>> sv/thin_lens_phase_mask.sv
// Thin-lens phase mask: one field pixel (row, col, Ex, Ey) enters per request on the slave
// stream and one result leaves per request on the master stream, one pixel per clock
// sustained unless the master side stalls. Five stages form the centred offsets, the squared
// radius, the aperture test and the phase angle, sixteen cordic stages make the phasor, and
// three stages round the phasor, multiply and round the complex products. A stall on the
// master side holds the whole pipeline; nothing is dropped or repeated. Config registers
// (lens kind, phase step, aperture radius squared, grid size) are written by the user on the
// always-ready config channel only while the stream is idle; the block does not enforce it.
// depends on tlpm_pkg, tlpm_cordic
module thin_lens_phase_mask #(
    parameter int MAX_GRID    = tlpm_pkg::MAX_GRID_DEF,
    parameter int SAMPLE_BITS = tlpm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // config write channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [tlpm_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [tlpm_pkg::CFG_W-1:0]             i_cfg_data,
    // slave stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // row, col, ex_re, ex_im, ey_re, ey_im, zero pad
    input  logic [((2*tlpm_pkg::IDX_W+4*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // master stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // ex_re_out, ex_im_out, ey_re_out, ey_im_out, zero pad
    output logic [((4*SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata,
    // inside_aperture
    output logic                                   m_axis_tuser
);

    localparam int SB    = SAMPLE_BITS;
    localparam int IW    = tlpm_pkg::IDX_W;
    localparam int GC_W  = $clog2(MAX_GRID + 1);
    localparam int G_W   = (GC_W > tlpm_pkg::GRID_W) ? GC_W : tlpm_pkg::GRID_W;
    localparam int SQ_W  = 2*G_W - 2;
    localparam int R2_W  = SQ_W + 1;
    localparam int CW    = tlpm_pkg::CORDIC_W;
    localparam int PW    = tlpm_pkg::PHASOR_W;
    localparam int PR_W  = SB + PW;
    localparam int SUM_W = PR_W + 2;
    localparam int SIDE_W = 4*SB + 2;

    typedef logic signed [SB-1:0] t_smp4 [4];

    // config registers
    logic                          r_lens_kind;
    logic [tlpm_pkg::PHASE_W-1:0]  r_phase_step;
    logic [tlpm_pkg::APER_W-1:0]   r_aperture;
    logic [tlpm_pkg::GRID_W-1:0]   r_grid_size;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lens_kind  <= tlpm_pkg::LENS_CONVEX;
            r_phase_step <= '0;
            r_aperture   <= tlpm_pkg::APER_RESET;
            r_grid_size  <= tlpm_pkg::GRID_RESET;
        end else if (i_cfg_valid) begin
            unique case (tlpm_pkg::t_cfg_idx'(i_cfg_index))
                tlpm_pkg::CFG_LENS_KIND:  r_lens_kind  <= i_cfg_data[0];
                tlpm_pkg::CFG_PHASE_STEP: r_phase_step <= i_cfg_data;
                tlpm_pkg::CFG_APERTURE:   r_aperture   <= i_cfg_data[tlpm_pkg::APER_W-1:0];
                tlpm_pkg::CFG_GRID_SIZE:  r_grid_size  <= i_cfg_data[tlpm_pkg::GRID_W-1:0];
                default: ;
            endcase
        end
    end

    // global advance: the output register is free or being taken
    logic w_en;
    logic r_o_valid;
    assign w_en          = !r_o_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    // input unpacking
    logic [IW-1:0] w_row, w_col;
    t_smp4         w_smp;
    assign w_row    = s_axis_tdata[IW-1:0];
    assign w_col    = s_axis_tdata[2*IW-1:IW];
    assign w_smp[0] = s_axis_tdata[2*IW+0*SB +: SB];
    assign w_smp[1] = s_axis_tdata[2*IW+1*SB +: SB];
    assign w_smp[2] = s_axis_tdata[2*IW+2*SB +: SB];
    assign w_smp[3] = s_axis_tdata[2*IW+3*SB +: SB];

    // stage 1: clamp grid and form centred offsets
    logic [G_W-1:0]        w_grid, w_gclamp, w_half;
    logic signed [G_W-1:0] n_dx, n_dy;
    logic signed [G_W-1:0] r_dx, r_dy;
    logic [4*SB-1:0]       r_smp1;
    logic                  r_v1;

    always_comb begin
        w_grid   = G_W'(r_grid_size);
        w_gclamp = (w_grid > G_W'(MAX_GRID)) ? G_W'(MAX_GRID) : w_grid;
        w_half   = w_gclamp >> 1;
        n_dx     = $signed(G_W'(w_row)) - $signed(w_half);
        n_dy     = $signed(G_W'(w_col)) - $signed(w_half);
    end

    // stage 2: squares
    logic signed [2*G_W-1:0] w_sqx, w_sqy;
    logic [SQ_W-1:0]         r_sqx, r_sqy;
    logic [4*SB-1:0]         r_smp2;
    logic                    r_v2;
    assign w_sqx = r_dx * r_dx;
    assign w_sqy = r_dy * r_dy;

    // stage 3: radius and aperture test
    logic [R2_W-1:0] n_r2, r_r2;
    logic            r_inside3;
    logic [4*SB-1:0] r_smp3;
    logic            r_v3;
    assign n_r2 = {1'b0, r_sqx} + {1'b0, r_sqy};

    // stage 4: angle = phase_step * r2 modulo one turn
    logic [tlpm_pkg::PHASE_W+R2_W-1:0] w_angle_full;
    logic [tlpm_pkg::PHASE_W-1:0]      r_angle;
    logic                              r_inside4;
    logic [4*SB-1:0]                   r_smp4;
    logic                              r_v4;
    assign w_angle_full = r_phase_step * r_r2;

    // stage 5: sign by lens kind and quadrant fold
    logic [tlpm_pkg::PHASE_W-1:0] w_ang_s, w_ang_q, w_ang_f;
    logic                         w_flip;
    logic signed [CW-1:0]         r_z;
    logic [SIDE_W-1:0]            r_side5;
    logic                         r_v5;

    always_comb begin
        w_ang_s = (r_lens_kind == tlpm_pkg::LENS_CONVEX) ? (~r_angle + 1'b1) : r_angle;
        w_ang_q = w_ang_s + tlpm_pkg::QUARTER_TURN;
        w_flip  = w_ang_q[tlpm_pkg::PHASE_W-1];
        w_ang_f = w_flip ? (w_ang_s + tlpm_pkg::HALF_TURN) : w_ang_s;
    end

    // register stages 1 to 5, valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // register stages 1 to 5, payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dx      <= n_dx;
            r_dy      <= n_dy;
            r_smp1    <= {w_smp[3], w_smp[2], w_smp[1], w_smp[0]};
            r_sqx     <= w_sqx[SQ_W-1:0];
            r_sqy     <= w_sqy[SQ_W-1:0];
            r_smp2    <= r_smp1;
            r_r2      <= n_r2;
            r_inside3 <= (n_r2 <= R2_W'(r_aperture));
            r_smp3    <= r_smp2;
            r_angle   <= w_angle_full[tlpm_pkg::PHASE_W-1:0];
            r_inside4 <= r_inside3;
            r_smp4    <= r_smp3;
            r_z       <= $signed({w_ang_f[tlpm_pkg::PHASE_W-1], w_ang_f});
            r_side5   <= {w_flip, r_inside4, r_smp4};
        end
    end

    // cordic stages
    tlpm_pkg::t_pipe_ctl  w_ctl;
    logic                 w_cv;
    logic signed [CW-1:0] w_cx, w_cy;
    logic [SIDE_W-1:0]    w_cside;
    assign w_ctl.en    = w_en;
    assign w_ctl.valid = r_v5;

    tlpm_cordic #(
        .SIDE_W (SIDE_W)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_z     (r_z),
        .i_side  (r_side5),
        .o_valid (w_cv),
        .o_x     (w_cx),
        .o_y     (w_cy),
        .o_side  (w_cside)
    );

    // phasor stage: undo the fold, round and saturate to Q1.15
    logic signed [CW-1:0]  w_xf, w_yf, w_xr, w_yr;
    logic signed [PW-1:0]  n_cos, n_sin, r_cos, r_sin;
    logic [SIDE_W-2:0]     r_sidec;
    logic                  r_vc;
    localparam logic signed [CW-1:0] PH_MAX = CW'((1 << (PW-1)) - 1);
    localparam logic signed [CW-1:0] PH_MIN = -CW'(1 << (PW-1));

    always_comb begin
        w_xf = w_cside[SIDE_W-1] ? -w_cx : w_cx;
        w_yf = w_cside[SIDE_W-1] ? -w_cy : w_cy;
        w_xr = (w_xf + CW'(tlpm_pkg::ROUND_HALF)) >>> tlpm_pkg::FRAC_SHIFT;
        w_yr = (w_yf + CW'(tlpm_pkg::ROUND_HALF)) >>> tlpm_pkg::FRAC_SHIFT;
        if (w_xr > PH_MAX)      n_cos = PH_MAX[PW-1:0];
        else if (w_xr < PH_MIN) n_cos = PH_MIN[PW-1:0];
        else                    n_cos = w_xr[PW-1:0];
        if (w_yr > PH_MAX)      n_sin = PH_MAX[PW-1:0];
        else if (w_yr < PH_MIN) n_sin = PH_MIN[PW-1:0];
        else                    n_sin = w_yr[PW-1:0];
    end

    // product stage: eight real products
    t_smp4 w_smpc;
    assign w_smpc[0] = r_sidec[0*SB +: SB];
    assign w_smpc[1] = r_sidec[1*SB +: SB];
    assign w_smpc[2] = r_sidec[2*SB +: SB];
    assign w_smpc[3] = r_sidec[3*SB +: SB];

    logic signed [PR_W-1:0] r_ac [4];
    logic signed [PR_W-1:0] r_as [4];
    logic [SIDE_W-2:0]      r_sidep;
    logic                   r_vp;

    // output stage: sums, rounding, saturation and aperture select
    t_smp4 w_smpp;
    assign w_smpp[0] = r_sidep[0*SB +: SB];
    assign w_smpp[1] = r_sidep[1*SB +: SB];
    assign w_smpp[2] = r_sidep[2*SB +: SB];
    assign w_smpp[3] = r_sidep[3*SB +: SB];

    function automatic logic signed [SB-1:0] round_sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] t;
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        t  = (v + SUM_W'(tlpm_pkg::ROUND_HALF)) >>> tlpm_pkg::FRAC_SHIFT;
        hi = SUM_W'((64'sd1 <<< (SB-1)) - 64'sd1);
        lo = -hi - SUM_W'(1);
        if (t > hi)      return hi[SB-1:0];
        else if (t < lo) return lo[SB-1:0];
        else             return t[SB-1:0];
    endfunction

    t_smp4 n_out;
    logic [4*SB-1:0] r_out;
    logic            r_out_inside;

    always_comb begin
        if (r_sidep[4*SB]) begin
            n_out[0] = round_sat(SUM_W'(r_ac[0]) - SUM_W'(r_as[1]));
            n_out[1] = round_sat(SUM_W'(r_as[0]) + SUM_W'(r_ac[1]));
            n_out[2] = round_sat(SUM_W'(r_ac[2]) - SUM_W'(r_as[3]));
            n_out[3] = round_sat(SUM_W'(r_as[2]) + SUM_W'(r_ac[3]));
        end else if (r_lens_kind == tlpm_pkg::LENS_CONCAVE) begin
            n_out[0] = '0;
            n_out[1] = '0;
            n_out[2] = '0;
            n_out[3] = '0;
        end else begin
            n_out = w_smpp;
        end
    end

    // valid bits of the tail stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc      <= 1'b0;
            r_vp      <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_vc      <= w_cv;
            r_vp      <= r_vc;
            r_o_valid <= r_vp;
        end
    end

    // payload of the tail stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cos   <= n_cos;
            r_sin   <= n_sin;
            r_sidec <= w_cside[SIDE_W-2:0];
            for (int k = 0; k < 4; k++) begin
                r_ac[k] <= w_smpc[k] * r_cos;
                r_as[k] <= w_smpc[k] * r_sin;
            end
            r_sidep      <= r_sidec;
            r_out        <= {n_out[3], n_out[2], n_out[1], n_out[0]};
            r_out_inside <= r_sidep[4*SB];
        end
    end

    // output packing
    always_comb begin
        m_axis_tdata           = '0;
        m_axis_tdata[4*SB-1:0] = r_out;
    end
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tuser  = r_out_inside;

`ifndef SYNTHESIS
    // a concave lens blacks out everything outside the aperture
    a_concave_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser && r_lens_kind == tlpm_pkg::LENS_CONCAVE)
        |-> (r_out == '0))
        else $error("concave lens output outside aperture is not zero");

    // a stall freezes the valid bits of stage 1, stage 5, the phasor stage and the product stage
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_v1) && $stable(r_v5) && $stable(r_vc) && $stable(r_vp)))
        else $error("pipeline valid bits moved during a stall");

    // zero phase step gives a phasor of about one
    a_zero_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vc && r_phase_step == '0) |-> (r_cos >= 16'sd32000 && r_sin <= 16'sd8
                                          && r_sin >= -16'sd8))
        else $error("phasor for zero phase is not close to one");
`endif

endmodule
